@@ sv/three_way_sorted_merge_macros.svh @@
// Assertion helpers for the three way sorted merge block.
`ifndef THREE_WAY_SORTED_MERGE_MACROS_SVH
`define THREE_WAY_SORTED_MERGE_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define TSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked implication check, switched off while reset is asserted.
`define TSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, switched off while reset is asserted.
`define TSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tsm_pkg.sv @@
package tsm_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 256;
  localparam int NUM_QUEUES  = 3;
  localparam int DATA_W      = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Remaining count field, saturating
  localparam int REMAIN_W   = 10;
  localparam int REMAIN_MAX = 1023;
  localparam int SUM_W      = (CNT_W + 2 > REMAIN_W + 1) ? CNT_W + 2 : REMAIN_W + 1;

  // Commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Source code when nothing was popped
  localparam logic [1:0] NO_SOURCE = 2'd3;
  localparam logic [1:0] LAST_Q    = 2'd2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [1:0]               command;
    logic [1:0]               stream;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               source;
    logic [1:0]               status;
    logic [REMAIN_W-1:0]      remaining;
  } rsp_t;

  // Running minimum held by the compare unit
  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value;
    logic [1:0]               source;
  } best_t;

  // Flat store address of an entry of one queue
  function automatic addr_t queue_addr(logic [1:0] q, ptr_t p);
    return addr_t'(addr_t'(q) * addr_t'(QUEUE_DEPTH)) + addr_t'(p);
  endfunction

  // Ring pointer advance, any depth
  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

endpackage

@@ sv/tsm_mem.sv @@
module tsm_mem (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  tsm_pkg::addr_t                    waddr_i,
  input  logic signed [tsm_pkg::DATA_W-1:0] wdata_i,
  input  logic                              re_i,
  input  tsm_pkg::addr_t                    raddr_i,
  output logic signed [tsm_pkg::DATA_W-1:0] rdata_o
);

  logic signed [tsm_pkg::DATA_W-1:0] mem_q [tsm_pkg::MEM_DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/tsm_cmp.sv @@
module tsm_cmp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clr_i,
  input  logic                              en_i,
  input  logic signed [tsm_pkg::DATA_W-1:0] cand_i,
  input  logic [1:0]                        cand_src_i,
  output tsm_pkg::best_t                    best_o
);

  logic                              found_q;
  logic signed [tsm_pkg::DATA_W-1:0] value_q;
  logic [1:0]                        src_q;
  logic                              take;

  // Strict less-than keeps the earlier queue on ties
  assign take = en_i && (!found_q || (cand_i < value_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q <= cand_i;
      src_q   <= cand_src_i;
    end
  end

  assign best_o = '{found: found_q, value: value_q, source: src_q};

endmodule

@@ sv/three_way_sorted_merge.sv @@
// Channel   | Signals                 | Handshake
// ----------+-------------------------+-----------------------------------------
// request   | start, busy, req_i      | taken on a clock edge with start && !busy
// result    | valid_o, rsp_o          | one-cycle strobe, receiver cannot stall
//
// Push, clear, empty pop and unused commands: busy while decoding, strobe in the next cycle.
// A pop with data stays busy through decode, then one store read port and one shared
// comparator visit the three queue heads in turn (read, compare), then the pointers
// update; the strobe follows in the next cycle.
// busy is high from the request edge to the result cycle; a new request may be taken
// in the cycle that shows the result. The receiver cannot stall.
// Reset empties all queues at once; the entry store itself is not cleared.
`include "three_way_sorted_merge_macros.svh"

module three_way_sorted_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tsm_pkg::req_t req_i,
  output logic          valid_o,
  output tsm_pkg::rsp_t rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state_q, state_d;
  tsm_pkg::req_t req_q, req_d;
  logic [1:0]    idx_q, idx_d;

  tsm_pkg::ptr_t head_q [tsm_pkg::NUM_QUEUES];
  tsm_pkg::ptr_t head_d [tsm_pkg::NUM_QUEUES];
  tsm_pkg::ptr_t tail_q [tsm_pkg::NUM_QUEUES];
  tsm_pkg::ptr_t tail_d [tsm_pkg::NUM_QUEUES];
  tsm_pkg::cnt_t cnt_q  [tsm_pkg::NUM_QUEUES];
  tsm_pkg::cnt_t cnt_d  [tsm_pkg::NUM_QUEUES];

  logic                              valid_q, valid_d;
  logic signed [tsm_pkg::DATA_W-1:0] res_val_q, res_val_d;
  logic [1:0]                        src_q, src_d;
  logic [1:0]                        status_q, status_d;

  logic                              mem_we, mem_re;
  tsm_pkg::addr_t                    mem_waddr, mem_raddr;
  logic signed [tsm_pkg::DATA_W-1:0] mem_rdata;

  logic           cmp_clr, cmp_en;
  tsm_pkg::best_t best;

  logic                       strm_ok;
  logic                       any_data;
  logic [tsm_pkg::SUM_W-1:0]  total;
  logic [tsm_pkg::REMAIN_W-1:0] remaining;

  logic fill_ok;
  logic empty_rsp;
  logic empty_fields;

  // Entry store
  tsm_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_q.value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared running-minimum comparator
  tsm_cmp u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cmp_clr),
    .en_i       (cmp_en),
    .cand_i     (mem_rdata),
    .cand_src_i (idx_q),
    .best_o     (best)
  );

  assign strm_ok  = (req_q.stream != tsm_pkg::NO_SOURCE);
  assign any_data = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);
  assign mem_waddr = tsm_pkg::queue_addr(req_q.stream, tail_q[req_q.stream]);
  assign mem_raddr = tsm_pkg::queue_addr(idx_q, head_q[idx_q]);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    res_val_d = res_val_q;
    src_d     = src_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    cmp_clr   = 1'b0;
    cmp_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_val_d = '0;
        src_d     = tsm_pkg::NO_SOURCE;
        status_d  = tsm_pkg::ST_OK;
        state_d   = S_IDLE;
        valid_d   = 1'b1;
        case (req_q.command)
          tsm_pkg::CMD_PUSH: begin
            if (strm_ok &&
                (cnt_q[req_q.stream] < tsm_pkg::cnt_t'(tsm_pkg::QUEUE_DEPTH))) begin
              mem_we                    = 1'b1;
              tail_d[req_q.stream]      = tsm_pkg::ptr_inc(tail_q[req_q.stream]);
              cnt_d[req_q.stream]       = tsm_pkg::cnt_t'(cnt_q[req_q.stream] +
                                                          tsm_pkg::cnt_t'(1));
            end else begin
              status_d = tsm_pkg::ST_DROPPED;
            end
          end
          tsm_pkg::CMD_POP: begin
            if (any_data) begin
              valid_d = 1'b0;
              cmp_clr = 1'b1;
              idx_d   = '0;
              state_d = S_RD;
            end else begin
              status_d = tsm_pkg::ST_EMPTY;
            end
          end
          tsm_pkg::CMD_CLEAR: begin
            for (int q = 0; q < tsm_pkg::NUM_QUEUES; q++) begin
              head_d[q] = '0;
              tail_d[q] = '0;
              cnt_d[q]  = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmp_en = (cnt_q[idx_q] != '0);
        if (idx_q == tsm_pkg::LAST_Q) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_FIN: begin
        head_d[best.source] = tsm_pkg::ptr_inc(head_q[best.source]);
        cnt_d[best.source]  = tsm_pkg::cnt_t'(cnt_q[best.source] - tsm_pkg::cnt_t'(1));
        res_val_d = best.value;
        src_d     = best.source;
        status_d  = tsm_pkg::ST_OK;
        valid_d   = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
      for (int q = 0; q < tsm_pkg::NUM_QUEUES; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_val_q <= res_val_d;
    src_q     <= src_d;
    status_q  <= status_d;
  end

  // Total fill, saturated to the field
  assign total = tsm_pkg::SUM_W'(cnt_q[0]) + tsm_pkg::SUM_W'(cnt_q[1]) +
                 tsm_pkg::SUM_W'(cnt_q[2]);
  assign remaining = (total > tsm_pkg::SUM_W'(tsm_pkg::REMAIN_MAX)) ?
                     tsm_pkg::REMAIN_W'(tsm_pkg::REMAIN_MAX) :
                     tsm_pkg::REMAIN_W'(total);

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = '{result_value: res_val_q, source: src_q, status: status_q,
                     remaining: remaining};

  // Check terms
  assign fill_ok = (cnt_q[0] <= tsm_pkg::cnt_t'(tsm_pkg::QUEUE_DEPTH)) &&
                   (cnt_q[1] <= tsm_pkg::cnt_t'(tsm_pkg::QUEUE_DEPTH)) &&
                   (cnt_q[2] <= tsm_pkg::cnt_t'(tsm_pkg::QUEUE_DEPTH));
  assign empty_rsp    = valid_o && (rsp_o.status == tsm_pkg::ST_EMPTY);
  assign empty_fields = (rsp_o.source == tsm_pkg::NO_SOURCE) && (rsp_o.remaining == '0);

  // Checks
  `TSM_ASSERT_NXT(a_one_cycle_strobe, valid_o, !valid_o, "result strobe held two cycles")
  `TSM_ASSERT_NXT(a_request_busy, start && !busy, busy, "request taken but block not busy")
  `TSM_ASSERT(a_fill_bound, fill_ok, "queue fill count above depth")
  `TSM_ASSERT_IMP(a_empty_pop, empty_rsp, empty_fields, "empty pop with data or source")
  `TSM_ASSERT_IMP(a_fin_found, state_q == S_FIN, best.found, "pop finished with no head")

endmodule
